// ===== design/mpsp_pkg.sv =====
// Package for the MQTT packet stream parser: result record, role, kind and status codes.
// Used by the parser front end, the result queue and the top level. No dependencies.
`timescale 1ns / 1ps

package mpsp_pkg;

    // Byte roles
    localparam logic [2:0] ROLE_TYPE    = 3'd0;
    localparam logic [2:0] ROLE_LENGTH  = 3'd1;
    localparam logic [2:0] ROLE_TOPICLN = 3'd2;
    localparam logic [2:0] ROLE_TOPIC   = 3'd3;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd4;
    localparam logic [2:0] ROLE_OTHER   = 3'd5;

    // Packet kinds
    localparam logic [2:0] KIND_PUBLISH = 3'd0;
    localparam logic [2:0] KIND_CONNACK = 3'd1;
    localparam logic [2:0] KIND_SUBACK  = 3'd2;
    localparam logic [2:0] KIND_PINGRSP = 3'd3;
    localparam logic [2:0] KIND_OTHER   = 3'd4;

    // MQTT control packet type codes
    localparam logic [3:0] TYPE_CONNACK = 4'd2;
    localparam logic [3:0] TYPE_PUBLISH = 4'd3;
    localparam logic [3:0] TYPE_SUBACK  = 4'd9;
    localparam logic [3:0] TYPE_PINGRSP = 4'd13;

    // End-of-packet status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_LEN_LONG  = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    // One tagged output byte
    typedef struct packed {
        logic [7:0]  byte_value;
        logic [2:0]  byte_role;
        logic [2:0]  packet_kind;
        logic [15:0] topic_length;
        logic        packet_end;
        logic [1:0]  status;
    } mpsp_result_t;

    // Packet type nibble to kind code
    function automatic logic [2:0] kind_of(input logic [3:0] ptype);
        logic [2:0] k;
        unique case (ptype)
            TYPE_PUBLISH: k = KIND_PUBLISH;
            TYPE_CONNACK: k = KIND_CONNACK;
            TYPE_SUBACK:  k = KIND_SUBACK;
            TYPE_PINGRSP: k = KIND_PINGRSP;
            default:      k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

// ===== design/mpsp_front.sv =====
// Parser front end: classifies each accepted byte and updates the packet state.
// Depends on mpsp_pkg.
`timescale 1ns / 1ps

module mpsp_front
    import mpsp_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_fire,
    input  logic [7:0]   rx_byte,
    output mpsp_result_t result
);

    typedef enum logic [2:0] {
        PH_TYPE, PH_LEN, PH_TLHI, PH_TLLO, PH_TOPIC, PH_PAYLOAD, PH_BODY
    } phase_t;

    localparam logic [2:0] MAX_LB = 3'(MAX_LENGTH_BYTES);

    phase_t      phase_reg, phase_next;
    logic [3:0]  type_reg, type_next;
    logic [27:0] accum_reg, accum_next;
    logic [1:0]  lcnt_reg, lcnt_next;
    logic [27:0] body_reg, body_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [15:0] tleft_reg, tleft_next;
    logic [1:0]  err_reg, err_next;

    logic [27:0] len_group;
    logic [27:0] accum_sum;
    logic [2:0]  lcnt_plus;
    logic [27:0] body_dec;
    logic        body_last;
    logic [15:0] tleft_dec;
    logic [15:0] tlen_full;
    logic        publish;
    logic [2:0]  role;
    logic        pend;
    logic [1:0]  st;
    logic [15:0] tl;

    // Shared arithmetic for the current byte
    always_comb begin
        case (lcnt_reg)
            2'd0:    len_group = {21'd0, rx_byte[6:0]};
            2'd1:    len_group = {14'd0, rx_byte[6:0], 7'd0};
            2'd2:    len_group = {7'd0, rx_byte[6:0], 14'd0};
            default: len_group = {rx_byte[6:0], 21'd0};
        endcase
    end

    assign accum_sum = accum_reg + len_group;
    assign lcnt_plus = {1'b0, lcnt_reg} + 3'd1;
    assign body_dec  = body_reg - 28'd1;
    assign body_last = (body_dec == 28'd0);
    assign tleft_dec = tleft_reg - 16'd1;
    assign tlen_full = {tlen_reg[15:8], rx_byte};
    assign publish   = (type_reg == TYPE_PUBLISH);

    // Phase decoder: next state and byte tags
    always_comb begin
        phase_next = phase_reg;
        type_next  = type_reg;
        accum_next = accum_reg;
        lcnt_next  = lcnt_reg;
        body_next  = body_reg;
        tlen_next  = tlen_reg;
        tleft_next = tleft_reg;
        err_next   = err_reg;
        role       = ROLE_TYPE;
        pend       = 1'b0;
        st         = ST_OK;
        tl         = 16'd0;

        unique case (phase_reg)
            PH_LEN: begin
                role       = ROLE_LENGTH;
                accum_next = accum_sum;
                if (rx_byte[7]) begin
                    if (lcnt_plus >= MAX_LB) begin
                        pend       = 1'b1;
                        st         = ST_LEN_LONG;
                        phase_next = PH_TYPE;
                    end else begin
                        lcnt_next = lcnt_plus[1:0];
                    end
                end else if (accum_sum == 28'd0) begin
                    pend       = 1'b1;
                    st         = publish ? ST_MALFORMED : ST_OK;
                    phase_next = PH_TYPE;
                end else begin
                    body_next  = accum_sum;
                    phase_next = publish ? PH_TLHI : PH_BODY;
                end
            end
            PH_TLHI: begin
                role      = ROLE_TOPICLN;
                tlen_next = {rx_byte, 8'd0};
                body_next = body_dec;
                if (body_last) begin
                    pend       = 1'b1;
                    st         = ST_MALFORMED;
                    phase_next = PH_TYPE;
                end else begin
                    phase_next = PH_TLLO;
                end
            end
            PH_TLLO: begin
                role      = ROLE_TOPICLN;
                tlen_next = tlen_full;
                tl        = tlen_full;
                body_next = body_dec;
                if (body_last) begin
                    pend       = 1'b1;
                    phase_next = PH_TYPE;
                    if (tlen_full != 16'd0) begin
                        err_next = ST_MALFORMED;
                        st       = ST_MALFORMED;
                    end else begin
                        st = err_reg;
                    end
                end else begin
                    // topic longer than what is left of the body
                    if ({12'd0, tlen_full} > body_dec) err_next = ST_MALFORMED;
                    tleft_next = tlen_full;
                    phase_next = (tlen_full != 16'd0) ? PH_TOPIC : PH_PAYLOAD;
                end
            end
            PH_TOPIC: begin
                role       = ROLE_TOPIC;
                tl         = tlen_reg;
                tleft_next = tleft_dec;
                body_next  = body_dec;
                if (body_last) begin
                    pend       = 1'b1;
                    st         = err_reg;
                    phase_next = PH_TYPE;
                end else if (tleft_dec == 16'd0) begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                role      = ROLE_PAYLOAD;
                tl        = tlen_reg;
                body_next = body_dec;
                if (body_last) begin
                    pend       = 1'b1;
                    st         = err_reg;
                    phase_next = PH_TYPE;
                end
            end
            PH_BODY: begin
                role      = ROLE_OTHER;
                body_next = body_dec;
                if (body_last) begin
                    pend       = 1'b1;
                    phase_next = PH_TYPE;
                end
            end
            default: begin
                // type byte, also taken for the unused phase code
                type_next  = rx_byte[7:4];
                accum_next = 28'd0;
                lcnt_next  = 2'd0;
                body_next  = 28'd0;
                tlen_next  = 16'd0;
                tleft_next = 16'd0;
                err_next   = ST_OK;
                phase_next = PH_LEN;
            end
        endcase
    end

    assign result.byte_value   = rx_byte;
    assign result.byte_role    = role;
    assign result.packet_kind  = kind_of(type_next);
    assign result.topic_length = tl;
    assign result.packet_end   = pend;
    assign result.status       = st;

    // Packet state, advanced on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TYPE;
            type_reg  <= 4'd0;
            accum_reg <= 28'd0;
            lcnt_reg  <= 2'd0;
            body_reg  <= 28'd0;
            tlen_reg  <= 16'd0;
            tleft_reg <= 16'd0;
            err_reg   <= 2'd0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            accum_reg <= accum_next;
            lcnt_reg  <= lcnt_next;
            body_reg  <= body_next;
            tlen_reg  <= tlen_next;
            tleft_reg <= tleft_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ===== design/mpsp_queue.sv =====
// Two-entry result queue between the parser front end and the output channel.
// Depends on mpsp_pkg.
`timescale 1ns / 1ps

module mpsp_queue
    import mpsp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  mpsp_result_t push_data,
    output logic         full,
    output logic         out_valid,
    input  logic         out_ready,
    output mpsp_result_t out_data
);

    mpsp_result_t mem [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== design/mqtt_packet_stream_parser_core.sv =====
// MQTT packet stream parser, top level: parser front end feeding a result queue.
// Depends on mpsp_pkg, mpsp_front and mpsp_queue.
`timescale 1ns / 1ps

// Takes one received byte per transfer on the s_ channel and returns exactly one
// tagged byte per input on the m_ channel, in order. Throughput is one byte per
// clock: the parser state is updated in the cycle of the input transfer, and the
// tagged byte is presented on m_ from the next cycle, out of a two-entry queue.
// s_ready drops only while that queue holds two undelivered bytes. Packet framing
// follows MQTT: type nibble, 7-bit variable length (up to MAX_LENGTH_BYTES bytes,
// longer flagged with status 1), and for PUBLISH the topic length, topic and
// payload. Status 2 marks a malformed PUBLISH; status is only non-zero at an end.
module mqtt_packet_stream_parser_core
    import mpsp_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_byte_value,
    output logic [2:0]  m_byte_role,
    output logic [2:0]  m_packet_kind,
    output logic [15:0] m_topic_length,
    output logic        m_packet_end,
    output logic [1:0]  m_status
);

    mpsp_result_t front_res;
    mpsp_result_t q_out;
    logic         q_full;
    logic         in_fire;

    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    // Classification and packet state
    mpsp_front #(
        .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .rx_byte (s_rx_byte),
        .result  (front_res)
    );

    // Result queue and output channel
    mpsp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire),
        .push_data (front_res),
        .full      (q_full),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (q_out)
    );

    assign m_byte_value   = q_out.byte_value;
    assign m_byte_role    = q_out.byte_role;
    assign m_packet_kind  = q_out.packet_kind;
    assign m_topic_length = q_out.topic_length;
    assign m_packet_end   = q_out.packet_end;
    assign m_status       = q_out.status;

endmodule

// ===== design/mpsp_checker.sv =====
// Port-level checks for the MQTT packet stream parser, bound to the top level.
// Depends on mpsp_pkg and mqtt_packet_stream_parser_core.
`timescale 1ns / 1ps

module mpsp_checker
    import mpsp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_rx_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_byte_value,
    input logic [2:0]  m_byte_role,
    input logic [2:0]  m_packet_kind,
    input logic [15:0] m_topic_length,
    input logic        m_packet_end,
    input logic [1:0]  m_status
);

    // A stalled input transfer holds its byte
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_rx_byte))
        else $error("input changed while stalled");

    // A stalled result transfer holds its byte
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_byte_value) && $stable(m_status))
        else $error("result changed while stalled");

    // Status is reported only at a packet end
    a_status_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> m_packet_end)
        else $error("status without packet end");

    // A type byte never ends a packet
    a_type_open: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_byte_role == ROLE_TYPE) |-> !m_packet_end)
        else $error("type byte marked as packet end");

    // Topic length shows only on publish topic length, topic and payload bytes
    a_tl_role: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_topic_length != 16'd0) |->
            (m_packet_kind == KIND_PUBLISH) &&
            ((m_byte_role == ROLE_TOPICLN) || (m_byte_role == ROLE_TOPIC) ||
             (m_byte_role == ROLE_PAYLOAD)))
        else $error("topic length on a foreign byte");

endmodule

bind mqtt_packet_stream_parser_core mpsp_checker u_mpsp_checker (.*);

// ===== tb/sv/tb_mqtt_packet_stream_parser_core.sv =====
// Self-checking testbench for mqtt_packet_stream_parser_core: directed and random byte streams.
// Depends on mpsp_pkg and the parser RTL; predicts every tagged byte with its own parser model.
`timescale 1ns / 1ps

module tb_mqtt_packet_stream_parser_core;
    import mpsp_pkg::*;

    localparam int LEN_FIELD_MAX  = 4;
    localparam int STALL_LIMIT    = 1000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_BYTES   = 1100;
    localparam mpsp_result_t NO_WANT = '0;

    // Parser phases, as the predictor tracks them
    typedef enum logic [2:0] {
        PS_TYPE, PS_LENGTH, PS_TOPIC_LEN_HI, PS_TOPIC_LEN_LO, PS_TOPIC, PS_PAYLOAD, PS_BODY
    } parse_phase_t;

    // One directed row: input byte, whether a result is typed in, and that result
    typedef struct packed {
        logic [7:0]   rx;
        logic         typed;
        mpsp_result_t want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_byte_value;
    logic [2:0]  m_byte_role;
    logic [2:0]  m_packet_kind;
    logic [15:0] m_topic_length;
    logic        m_packet_end;
    logic [1:0]  m_status;

    // Predictor state
    parse_phase_t cur_phase      = PS_TYPE;
    logic [3:0]   cur_type       = '0;
    logic [27:0]  len_sum        = '0;
    logic [1:0]   len_idx        = '0;
    logic [27:0]  body_count     = '0;
    logic [15:0]  topic_len      = '0;
    logic [15:0]  topic_count    = '0;
    logic [1:0]   pending_status = '0;

    mpsp_result_t tagged_bytes_due[$];
    mpsp_result_t oldest_due;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           bytes_sent    = 0;
    int           fail_count    = 0;
    int           stall_cycles  = 0;

    // Directed stream: error endings and the opening type byte typed in, the rest predicted
    stim_row_t dir_rows [0:25] = '{
        // zero-length publish straight after reset
        {8'h30, 1'b1, {8'h30, ROLE_TYPE, KIND_PUBLISH, 16'd0, 1'b0, ST_OK}},
        {8'h00, 1'b1, {8'h00, ROLE_LENGTH, KIND_PUBLISH, 16'd0, 1'b1, ST_MALFORMED}},
        // unsupported type with an over-long length field
        {8'hF0, 1'b0, NO_WANT},
        {8'hFF, 1'b0, NO_WANT},
        {8'hFF, 1'b0, NO_WANT},
        {8'hFF, 1'b0, NO_WANT},
        {8'hFF, 1'b1, {8'hFF, ROLE_LENGTH, KIND_OTHER, 16'd0, 1'b1, ST_LEN_LONG}},
        // ping response, zero length spread over two length bytes
        {8'hD0, 1'b0, NO_WANT},
        {8'h80, 1'b0, NO_WANT},
        {8'h00, 1'b0, NO_WANT},
        // publish whose body is too short for the topic length
        {8'h32, 1'b0, NO_WANT},
        {8'h01, 1'b0, NO_WANT},
        {8'hAB, 1'b1, {8'hAB, ROLE_TOPICLN, KIND_PUBLISH, 16'd0, 1'b1, ST_MALFORMED}},
        // topic length 0xFFFF runs past the packet end
        {8'h3F, 1'b0, NO_WANT},
        {8'h04, 1'b0, NO_WANT},
        {8'hFF, 1'b0, NO_WANT},
        {8'hFF, 1'b0, NO_WANT},
        {8'h41, 1'b0, NO_WANT},
        {8'h42, 1'b1, {8'h42, ROLE_TOPIC, KIND_PUBLISH, 16'hFFFF, 1'b1, ST_MALFORMED}},
        // empty topic, padded length field, one payload byte
        {8'h30, 1'b0, NO_WANT},
        {8'h83, 1'b0, NO_WANT},
        {8'h80, 1'b0, NO_WANT},
        {8'h00, 1'b0, NO_WANT},
        {8'h00, 1'b0, NO_WANT},
        {8'h00, 1'b0, NO_WANT},
        {8'h7F, 1'b0, NO_WANT}
    };

    mqtt_packet_stream_parser_core #(
        .MAX_LENGTH_BYTES(LEN_FIELD_MAX)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_value   (m_byte_value),
        .m_byte_role    (m_byte_role),
        .m_packet_kind  (m_packet_kind),
        .m_topic_length (m_topic_length),
        .m_packet_end   (m_packet_end),
        .m_status       (m_status)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Counts one body byte down; true on the last byte of the packet
    function automatic logic count_body_byte();
        body_count = body_count - 28'd1;
        if (body_count == 28'd0) begin
            cur_phase = PS_TYPE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Works out the tagged byte for one received byte and advances the parser state
    function automatic mpsp_result_t predict_tagged_byte(input logic [7:0] rx);
        mpsp_result_t r;
        logic         is_pub;
        r = '0;
        r.byte_value = rx;
        is_pub = (cur_type == TYPE_PUBLISH);
        case (cur_phase)
            PS_LENGTH: begin
                r.byte_role = ROLE_LENGTH;
                len_sum = len_sum + (28'(rx[6:0]) << (7 * int'(len_idx)));
                if (rx[7]) begin
                    if (int'(len_idx) + 1 >= LEN_FIELD_MAX) begin
                        r.packet_end = 1'b1;
                        r.status = ST_LEN_LONG;
                        cur_phase = PS_TYPE;
                    end else begin
                        len_idx = len_idx + 2'd1;
                    end
                end else if (len_sum == 28'd0) begin
                    r.packet_end = 1'b1;
                    r.status = is_pub ? ST_MALFORMED : ST_OK;
                    cur_phase = PS_TYPE;
                end else begin
                    body_count = len_sum;
                    cur_phase = is_pub ? PS_TOPIC_LEN_HI : PS_BODY;
                end
            end
            PS_TOPIC_LEN_HI: begin
                r.byte_role = ROLE_TOPICLN;
                topic_len = {rx, 8'h00};
                if (count_body_byte()) begin
                    r.packet_end = 1'b1;
                    r.status = ST_MALFORMED;
                end else begin
                    cur_phase = PS_TOPIC_LEN_LO;
                end
            end
            PS_TOPIC_LEN_LO: begin
                r.byte_role = ROLE_TOPICLN;
                topic_len[7:0] = rx;
                r.topic_length = topic_len;
                if (count_body_byte()) begin
                    if (topic_len != 16'd0) pending_status = ST_MALFORMED;
                    r.packet_end = 1'b1;
                    r.status = pending_status;
                end else begin
                    if (28'(topic_len) > body_count) pending_status = ST_MALFORMED;
                    topic_count = topic_len;
                    cur_phase = (topic_count != 16'd0) ? PS_TOPIC : PS_PAYLOAD;
                end
            end
            PS_TOPIC: begin
                r.byte_role = ROLE_TOPIC;
                r.topic_length = topic_len;
                topic_count = topic_count - 16'd1;
                if (count_body_byte()) begin
                    r.packet_end = 1'b1;
                    r.status = pending_status;
                end else if (topic_count == 16'd0) begin
                    cur_phase = PS_PAYLOAD;
                end
            end
            PS_PAYLOAD: begin
                r.byte_role = ROLE_PAYLOAD;
                r.topic_length = topic_len;
                if (count_body_byte()) begin
                    r.packet_end = 1'b1;
                    r.status = pending_status;
                end
            end
            PS_BODY: begin
                r.byte_role = ROLE_OTHER;
                if (count_body_byte()) begin
                    r.packet_end = 1'b1;
                    r.status = ST_OK;
                end
            end
            default: begin
                // type byte opens a new packet
                r.byte_role = ROLE_TYPE;
                cur_type = rx[7:4];
                len_sum = '0;
                len_idx = '0;
                body_count = '0;
                topic_len = '0;
                topic_count = '0;
                pending_status = ST_OK;
                cur_phase = PS_LENGTH;
            end
        endcase
        case (cur_type)
            TYPE_PUBLISH: r.packet_kind = KIND_PUBLISH;
            TYPE_CONNACK: r.packet_kind = KIND_CONNACK;
            TYPE_SUBACK:  r.packet_kind = KIND_SUBACK;
            TYPE_PINGRSP: r.packet_kind = KIND_PINGRSP;
            default:      r.packet_kind = KIND_OTHER;
        endcase
        return r;
    endfunction

    // Offers one byte on s_, waits for the transfer, then queues its expected result
    task automatic push_byte(input logic [7:0] rx, input logic typed, input mpsp_result_t want);
        mpsp_result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= rx;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_tagged_byte(rx);
        tagged_bytes_due = {tagged_bytes_due, (typed ? want : predicted)};
        bytes_sent++;
    endtask

    // One random packet: mostly well formed, some noise, over-long and truncated ones
    task automatic send_random_packet();
        int          pick;
        int          body_len;
        int          sent_len;
        int          n_len;
        int          k;
        logic [3:0]  ptype;
        logic [15:0] tl;
        logic        is_pub;
        pick = $urandom_range(19);
        if (pick == 0) begin
            // stray bytes
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)), 1'b0, NO_WANT);
            return;
        end
        if (pick <= 8)       ptype = TYPE_PUBLISH;
        else if (pick <= 10) ptype = TYPE_CONNACK;
        else if (pick <= 12) ptype = TYPE_SUBACK;
        else if (pick <= 14) ptype = TYPE_PINGRSP;
        else                 ptype = 4'($urandom_range(15));
        is_pub = (ptype == TYPE_PUBLISH);
        push_byte({ptype, 4'($urandom_range(15))}, 1'b0, NO_WANT);

        // length field running past its limit
        if ($urandom_range(24) == 0) begin
            repeat (LEN_FIELD_MAX) push_byte(8'h80 | 8'($urandom_range(127)), 1'b0, NO_WANT);
            return;
        end

        body_len = ($urandom_range(15) == 0) ? $urandom_range(300) : $urandom_range(24);
        n_len = 1;
        while (n_len < LEN_FIELD_MAX && (body_len >> (7 * n_len)) != 0) n_len++;
        if ($urandom_range(7) == 0) n_len = $urandom_range(n_len, LEN_FIELD_MAX);
        for (k = 0; k < n_len; k++)
            push_byte({k < n_len - 1, 7'(body_len >> (7 * k))}, 1'b0, NO_WANT);

        // now and then the body is cut short and the next packet lands in it
        sent_len = ($urandom_range(19) == 0) ? $urandom_range(body_len) : body_len;
        tl = 16'd0;
        if (is_pub && body_len >= 2)
            tl = ($urandom_range(7) == 0) ? 16'($urandom_range(65535))
                                           : 16'($urandom_range(body_len - 2));
        for (k = 0; k < sent_len; k++) begin
            if (is_pub && body_len >= 2 && k == 0)
                push_byte(tl[15:8], 1'b0, NO_WANT);
            else if (is_pub && body_len >= 2 && k == 1)
                push_byte(tl[7:0], 1'b0, NO_WANT);
            else
                push_byte(8'($urandom_range(255)), 1'b0, NO_WANT);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Result side: random back-pressure, checking and the stall watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_valid && m_ready) begin
                if (tagged_bytes_due.size() == 0) begin
                    $error("tagged byte %02h with no expectation pending", m_byte_value);
                    fail_count++;
                end else begin
                    oldest_due = tagged_bytes_due.pop_front();
                    check_field("byte_value", 16'(oldest_due.byte_value), 16'(m_byte_value));
                    check_field("byte_role", 16'(oldest_due.byte_role), 16'(m_byte_role));
                    check_field("packet_kind", 16'(oldest_due.packet_kind),
                                16'(m_packet_kind));
                    check_field("topic_length", oldest_due.topic_length, m_topic_length);
                    check_field("packet_end", 16'(oldest_due.packet_end), 16'(m_packet_end));
                    check_field("status", 16'(oldest_due.status), 16'(m_status));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    // Stimulus
    initial begin
        int i;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 37;
        recv_idle_pct = 45;
        for (i = 0; i < 26; i++) push_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want);

        while (bytes_sent < RANDOM_BYTES) begin
            if (bytes_sent < 420) begin
                send_idle_pct = 37;
                recv_idle_pct = 45;
            end else if (bytes_sent < 780) begin
                send_idle_pct = 45;
                recv_idle_pct = 37;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_random_packet();
        end
        s_valid <= 1'b0;

        // drain, then keep watching the quiet output to catch anything extra
        while (tagged_bytes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mpsp_pkg.sv
design/mpsp_front.sv
design/mpsp_queue.sv
design/mqtt_packet_stream_parser_core.sv
design/mpsp_checker.sv
tb/sv/tb_mqtt_packet_stream_parser_core.sv
